>>> design/sws_pkg.sv
package sws_pkg;

   localparam int SAMPLE_W = 16;
   localparam int SUM_OUT_W = 26;
   localparam int INDEX_W = 16;
   localparam int WIN_CFG_W = 11;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last_sample;
   } req_type;

   typedef struct packed {
      logic signed [SUM_OUT_W-1:0] best_sum;
      logic [INDEX_W-1:0]          first_start;
      logic [INDEX_W-1:0]          last_start;
      logic                        too_short;
   } rsp_type;

   // control of the item held between the front end and the tracker
   typedef struct packed {
      logic valid;
      logic last;
   } item_ctl_type;

endpackage

>>> design/sws_front.sv
module sws_front #(
   parameter int MAX_WINDOW = 1024,
   parameter int MAX_SAMPLES = 65536,
   parameter int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
   parameter int LW = $clog2(MAX_WINDOW + 1),
   parameter int PW = $clog2(MAX_SAMPLES)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [sws_pkg::WIN_CFG_W-1:0]       csr_wr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  sws_pkg::req_type                    req_data,
   output sws_pkg::item_ctl_type               item_ctl,
   output logic signed [sws_pkg::SAMPLE_W-1:0] item_sample,
   output logic signed [sws_pkg::SAMPLE_W-1:0] item_old,
   output logic [PW-1:0]                       item_pos,
   output logic [LW-1:0]                       item_len,
   input  logic                                item_take
);
   import sws_pkg::*;

   localparam int CFGW = (WIN_CFG_W > LW) ? WIN_CFG_W + 1 : LW + 1;

   logic [WIN_CFG_W-1:0] win_ff;
   logic [LW-1:0]        len_ff, len_in, len_cfg, len_now;
   logic [AW-1:0]        wptr_ff, wptr_in;
   logic [PW-1:0]        pos_ff, pos_in;
   logic [LW:0]          wptr_inc;
   logic [CFGW-1:0]      win_x;
   logic                 accept;
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_last_ff;
   logic signed [SAMPLE_W-1:0] s1_sample_ff, old_ff;
   logic [PW-1:0]        s1_pos_ff;
   logic [LW-1:0]        s1_len_ff;
   logic signed [SAMPLE_W-1:0] delay_mem [MAX_WINDOW];

   assign req_ready = !s1_valid_ff || item_take;
   assign accept = req_valid && req_ready;

   // zero means one, anything above the line depth saturates
   always_comb begin
      win_x = CFGW'(win_ff);
      if (win_x == '0) begin
         len_cfg = LW'(1);
      end else if (win_x > CFGW'(MAX_WINDOW)) begin
         len_cfg = LW'(MAX_WINDOW);
      end else begin
         len_cfg = LW'(win_x);
      end
   end

   // window length is latched on the first item of a sequence
   assign len_now = (pos_ff == '0) ? len_cfg : len_ff;
   assign wptr_inc = (LW + 1)'(wptr_ff) + (LW + 1)'(1);

   always_comb begin
      len_in = len_ff;
      wptr_in = wptr_ff;
      pos_in = pos_ff;
      if (accept) begin
         len_in = len_now;
         if (req_data.last_sample || wptr_inc == (LW + 1)'(len_now)) begin
            wptr_in = '0;
         end else begin
            wptr_in = AW'(wptr_inc);
         end
         if (req_data.last_sample) begin
            pos_in = '0;
         end else if (pos_ff != PW'(MAX_SAMPLES - 1)) begin
            pos_in = pos_ff + PW'(1);
         end
      end
   end

   assign s1_valid_in = accept ? 1'b1 : (item_take ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= WIN_CFG_W'(1);
         len_ff <= LW'(1);
         wptr_ff <= '0;
         pos_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            win_ff <= csr_wr_data;
         end
         len_ff <= len_in;
         wptr_ff <= wptr_in;
         pos_ff <= pos_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= req_data.sample;
         s1_last_ff <= req_data.last_sample;
         s1_pos_ff <= pos_ff;
         s1_len_ff <= len_now;
      end
   end

   // read-first: the old sample leaves as the new one is stored
   always_ff @(posedge clock) begin
      if (accept) begin
         old_ff <= delay_mem[wptr_ff];
         delay_mem[wptr_ff] <= req_data.sample;
      end
   end

   assign item_ctl.valid = s1_valid_ff;
   assign item_ctl.last = s1_last_ff;
   assign item_sample = s1_sample_ff;
   assign item_old = old_ff;
   assign item_pos = s1_pos_ff;
   assign item_len = s1_len_ff;

endmodule

>>> design/sws_track.sv
module sws_track #(
   parameter int MAX_WINDOW = 1024,
   parameter int LW = $clog2(MAX_WINDOW + 1),
   parameter int PW = 16,
   parameter int SW = sws_pkg::SAMPLE_W + $clog2(MAX_WINDOW)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sws_pkg::item_ctl_type               item_ctl,
   input  logic signed [sws_pkg::SAMPLE_W-1:0] item_sample,
   input  logic signed [sws_pkg::SAMPLE_W-1:0] item_old,
   input  logic [PW-1:0]                       item_pos,
   input  logic [LW-1:0]                       item_len,
   output logic                                item_take,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output sws_pkg::rsp_type                    rsp_data
);
   import sws_pkg::*;

   localparam int CW = ((PW > LW) ? PW : LW) + 1;
   localparam int EW = ((SW > SUM_OUT_W) ? SW : SUM_OUT_W) + 1;
   localparam logic signed [EW-1:0] SAT_HI = EW'((64'sd1 <<< (SUM_OUT_W - 1)) - 64'sd1);
   localparam logic signed [EW-1:0] SAT_LO = EW'(-(64'sd1 <<< (SUM_OUT_W - 1)));

   logic signed [SW-1:0] sum_ff, sum_in, best_ff, best_in, sum_new, old_term;
   logic [INDEX_W-1:0]   first_ff, first_in, last_ff, last_in, start;
   logic [CW-1:0]        pos_x, len_x;
   logic                 in_fill, at_full, short_seq;
   logic signed [EW-1:0] best_x;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   assign item_take = item_ctl.valid && (!item_ctl.last || !rsp_valid_ff || rsp_ready);

   assign pos_x = CW'(item_pos);
   assign len_x = CW'(item_len);
   assign in_fill = pos_x < len_x;
   assign at_full = (pos_x + CW'(1)) == len_x;
   assign short_seq = (pos_x + CW'(1)) < len_x;
   assign start = INDEX_W'(pos_x - len_x + CW'(1));

   // while the window fills nothing drops out of it
   assign old_term = in_fill ? '0 : SW'(item_old);
   assign sum_new = sum_ff + SW'(item_sample) - old_term;

   always_comb begin
      sum_in = sum_ff;
      best_in = best_ff;
      first_in = first_ff;
      last_in = last_ff;
      if (item_take) begin
         sum_in = sum_new;
         if (in_fill) begin
            if (at_full) begin
               best_in = sum_new;
               first_in = '0;
               last_in = '0;
            end
         end else if (sum_new > best_ff) begin
            best_in = sum_new;
            first_in = start;
            last_in = start;
         end else if (sum_new == best_ff) begin
            last_in = start;
         end
      end
   end

   assign best_x = EW'(best_in);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (item_take && item_ctl.last) begin
         rsp_valid_in = 1'b1;
         if (short_seq) begin
            rsp_in = '0;
            rsp_in.too_short = 1'b1;
         end else begin
            if (best_x > SAT_HI) begin
               rsp_in.best_sum = SUM_OUT_W'(SAT_HI);
            end else if (best_x < SAT_LO) begin
               rsp_in.best_sum = SUM_OUT_W'(SAT_LO);
            end else begin
               rsp_in.best_sum = SUM_OUT_W'(best_x);
            end
            rsp_in.first_start = first_in;
            rsp_in.last_start = last_in;
            rsp_in.too_short = 1'b0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         best_ff <= '0;
         first_ff <= '0;
         last_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // the last item closes the sequence
         if (item_take && item_ctl.last) begin
            sum_ff <= '0;
            best_ff <= '0;
            first_ff <= '0;
            last_ff <= '0;
         end else begin
            sum_ff <= sum_in;
            best_ff <= best_in;
            first_ff <= first_in;
            last_ff <= last_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

>>> design/sliding_window_max_sum.sv
// Greatest sum over all windows of csr_wr_data consecutive samples (0 reads as 1, values above
// MAX_WINDOW saturate), latched at the first item of each sequence. One item is taken every
// clock cycle while req_ready is high: the sample is written into the delay memory while the
// sample leaving the window is read from the same port; the registered item then takes one
// add, subtract and compare. The result of the item marked last_sample is registered, and
// req_ready only drops when such an item meets a result still waiting in the output register.
// too_short flags a sequence shorter than the window, with the other fields zero; best_sum
// saturates to 26 bits and the start indices are reported modulo 2^16.
module sliding_window_max_sum #(
   parameter int MAX_WINDOW = 1024,
   parameter int MAX_SAMPLES = 65536
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [sws_pkg::WIN_CFG_W-1:0]   csr_wr_data,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  sws_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output sws_pkg::rsp_type                rsp_data
);
   import sws_pkg::*;

   localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int LW = $clog2(MAX_WINDOW + 1);
   localparam int PW = $clog2(MAX_SAMPLES);
   localparam int SW = SAMPLE_W + $clog2(MAX_WINDOW);

   item_ctl_type               item_ctl;
   logic signed [SAMPLE_W-1:0] item_sample, item_old;
   logic [PW-1:0]              item_pos;
   logic [LW-1:0]              item_len;
   logic                       item_take;

   sws_front #(
      .MAX_WINDOW  (MAX_WINDOW),
      .MAX_SAMPLES (MAX_SAMPLES),
      .AW          (AW),
      .LW          (LW),
      .PW          (PW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .item_ctl    (item_ctl),
      .item_sample (item_sample),
      .item_old    (item_old),
      .item_pos    (item_pos),
      .item_len    (item_len),
      .item_take   (item_take)
   );

   sws_track #(
      .MAX_WINDOW (MAX_WINDOW),
      .LW         (LW),
      .PW         (PW),
      .SW         (SW)
   ) u_track (
      .clock       (clock),
      .reset       (reset),
      .item_ctl    (item_ctl),
      .item_sample (item_sample),
      .item_old    (item_old),
      .item_pos    (item_pos),
      .item_len    (item_len),
      .item_take   (item_take),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

`ifndef SYNTHESIS
   // a short sequence reports no sum and no indices
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.too_short |->
         rsp_data.best_sum == '0 && rsp_data.first_start == '0 && rsp_data.last_start == '0)
      else $error("too_short result carries nonzero fields");

   // input only stalls behind a result that is not being taken
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready && item_ctl.valid && item_ctl.last)
      else $error("input stalled without a blocked result");

   // a taken result never repeats unless a new last item was taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !(item_take && item_ctl.last) |=> !rsp_valid)
      else $error("result repeated after being taken");

   assert property (@(posedge clock) reset |=> !rsp_valid && !item_ctl.valid)
      else $error("pipeline not empty after reset");
`endif

endmodule
